// File: design/rfwe_pkg.sv
// rfwe_pkg: shared types and constants for the repeated fault window escalator
// used by rfwe_slot_eval and repeated_fault_window_escalator
package rfwe_pkg;

  localparam int unsigned TickW = 32;

  // result codes, message codes 0x28 0x29 0x30 0x31
  localparam logic [1:0] CODE_LOW_WARN   = 2'd0;
  localparam logic [1:0] CODE_HIGH_WARN  = 2'd1;
  localparam logic [1:0] CODE_LOW_PAUSE  = 2'd2;
  localparam logic [1:0] CODE_HIGH_PAUSE = 2'd3;

  localparam logic [TickW-1:0] WindowReset = 32'd1000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // update decided for one slot
  typedef struct packed {
    logic             wr;
    logic [TickW-1:0] wdata;
    logic             occupied;
  } slot_upd_t;

endpackage

// File: design/rfwe_ram.sv
// rfwe_ram: generic single write port, single read port ram with registered read
// no dependencies
module rfwe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/rfwe_slot_eval.sv
// rfwe_slot_eval: decides the new value of one timestamp slot and its occupancy
// depends on rfwe_pkg
module rfwe_slot_eval (
  input  logic [rfwe_pkg::TickW-1:0] slot,
  input  logic [rfwe_pkg::TickW-1:0] now,
  input  logic [rfwe_pkg::TickW-1:0] window,
  input  logic                       placed,
  output rfwe_pkg::slot_upd_t        upd
);

  logic [rfwe_pkg::TickW-1:0] age;
  logic                       cand;

  always_comb begin
    age  = now - slot;
    cand = (slot == '0) || (age > window);
    upd.wr    = cand;
    // first free or stale slot takes the tick, later ones are emptied
    upd.wdata = placed ? '0 : now;
    upd.occupied = cand ? (!placed && (now != '0)) : 1'b1;
  end

endmodule

// File: design/repeated_fault_window_escalator.sv
// repeated_fault_window_escalator: top level, sequencer around the slot ram
// depends on rfwe_pkg, rfwe_ram, rfwe_slot_eval
//
//   channel  signals                          payload
//   in       in_valid / in_ready              fault_kind, now_tick
//   out      out_valid / out_ready            escalate, fault_code, recent_count
//   cfg      cfg_wen                          cfg_wdata (window_ticks)
//
// an event is walked slot by slot from transfer to result: one ram read is
// issued per cycle and each slot is evaluated and written back the next cycle.
// reset is synchronous; slot contents are masked by per-entry valid bits, so
// no clearing pass is needed. a waiting result sits in the output register;
// the next event is taken once the walk ends and the result has moved there.
module repeated_fault_window_escalator #(
  parameter int SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        fault_kind,
  input  logic [31:0] now_tick,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        escalate,
  output logic [1:0]  fault_code,
  output logic [2:0]  recent_count,
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata
);

  localparam int Depth = 2 * SLOTS;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int SatCount = (SLOTS > 7) ? 7 : SLOTS;

  rfwe_pkg::state_t state, state_next;

  logic [rfwe_pkg::TickW-1:0] window_ticks;
  logic                       kind;
  logic [rfwe_pkg::TickW-1:0] now;
  logic                       placed;
  logic [CW-1:0]              count;
  logic [CW-1:0]              pos;
  logic                       res_esc;
  logic [CW-1:0]              res_count;
  logic [Depth-1:0]           valid;
  logic                       rd_valid;

  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              wr_addr;
  logic [rfwe_pkg::TickW-1:0] rd_data;
  logic [rfwe_pkg::TickW-1:0] slot_val;
  rfwe_pkg::slot_upd_t        upd;
  logic [CW-1:0]              count_next;
  logic                       last_slot;
  logic                       esc_now;
  logic                       accept;
  logic                       load_out;
  logic [AW-1:0]              base_in;
  logic [AW-1:0]              base_run;

  assign accept    = in_valid && in_ready;
  assign base_in   = fault_kind ? AW'(SLOTS) : '0;
  assign base_run  = kind ? AW'(SLOTS) : '0;
  assign slot_val  = rd_valid ? rd_data : '0;
  assign wr_addr   = base_run + AW'(pos);
  assign last_slot = (pos == CW'(SLOTS - 1));
  assign count_next = count + CW'(upd.occupied);
  assign esc_now   = (count_next == CW'(SLOTS));

  rfwe_slot_eval u_eval (
    .slot   (slot_val),
    .now    (now),
    .window (window_ticks),
    .placed (placed),
    .upd    (upd)
  );

  rfwe_ram #(
    .WIDTH (rfwe_pkg::TickW),
    .DEPTH (Depth)
  ) u_slots (
    .clk   (clk),
    .we    ((state == rfwe_pkg::ST_RUN) && upd.wr),
    .waddr (wr_addr),
    .wdata (upd.wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfwe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = base_in;
    load_out   = 1'b0;
    unique case (state)
      rfwe_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_valid;
        if (in_valid) begin
          state_next = rfwe_pkg::ST_RUN;
        end
      end
      rfwe_pkg::ST_RUN: begin
        rd_en   = !last_slot;
        rd_addr = base_run + AW'(pos) + AW'(1);
        if (last_slot) begin
          state_next = rfwe_pkg::ST_DONE;
        end
      end
      rfwe_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = rfwe_pkg::ST_IDLE;
        end
      end
      default: state_next = rfwe_pkg::ST_IDLE;
    endcase
  end

  // control and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= rfwe_pkg::WindowReset;
      valid        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        window_ticks <= cfg_wdata;
      end
      if (state == rfwe_pkg::ST_RUN) begin
        // full bank on the last slot: drop the whole bank
        if (last_slot && esc_now) begin
          for (int e = 0; e < Depth; e++) begin
            if ((e >= SLOTS) == kind) begin
              valid[e] <= 1'b0;
            end
          end
        end else if (upd.wr) begin
          valid[wr_addr] <= 1'b1;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_valid <= valid[rd_addr];
    end
    if (accept) begin
      kind   <= fault_kind;
      now    <= now_tick;
      placed <= 1'b0;
      count  <= '0;
      pos    <= '0;
    end else if (state == rfwe_pkg::ST_RUN) begin
      placed <= placed || upd.wr;
      count  <= count_next;
      pos    <= pos + CW'(1);
      if (last_slot) begin
        res_esc   <= esc_now;
        res_count <= count_next;
      end
    end
    if (load_out) begin
      escalate     <= res_esc;
      fault_code   <= res_esc ? (kind ? rfwe_pkg::CODE_HIGH_PAUSE : rfwe_pkg::CODE_LOW_PAUSE)
                              : (kind ? rfwe_pkg::CODE_HIGH_WARN : rfwe_pkg::CODE_LOW_WARN);
      recent_count <= (res_count > CW'(SatCount)) ? 3'(SatCount) : 3'(res_count);
    end
  end

  a_run_pos_in_bank: assert property (@(posedge clk) disable iff (rst)
    state == rfwe_pkg::ST_RUN |-> pos < CW'(SLOTS))
    else $error("slot walk ran past the bank");

  a_accept_starts_walk: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == rfwe_pkg::ST_RUN && pos == '0)
    else $error("transfer did not start a slot walk");

  a_escalate_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && escalate |-> recent_count == 3'(SatCount))
    else $error("escalation without a full bank");

  a_code_matches_escalate: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fault_code[1] == escalate)
    else $error("fault code disagrees with escalate");

endmodule
